FILE: hdl/assert_macros.svh
// Assertion macros shared by the front-end RTL.
// Each macro samples on clk; the reset-gated form is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/i2crf_pkg.sv
// Shared types and constants for the I2C target register-file front end.
// No dependencies; imported by the controller, datapath and top level.
package i2crf_pkg;

  // Bus event codes carried in the operation field
  localparam logic [1:0] OP_WRITE_ADDR = 2'd0;
  localparam logic [1:0] OP_DATA       = 2'd1;
  localparam logic [1:0] OP_READ_ADDR  = 2'd2;

  // PWM command codes
  localparam logic [1:0] PWM_NONE  = 2'd0;
  localparam logic [1:0] PWM_APPLY = 2'd1;
  localparam logic [1:0] PWM_START = 2'd2;
  localparam logic [1:0] PWM_STOP  = 2'd3;

  // Special data bytes
  localparam logic [7:0] READ_REQUEST_CODE = 8'hFF;
  localparam logic [7:0] GC_BYTE_APPLY     = 8'h52;  // 'R'
  localparam logic [7:0] GC_BYTE_START     = 8'h53;  // 'S'
  localparam logic [7:0] GC_BYTE_STOP      = 8'h50;  // 'P'

  // Write-protect mask covers the largest store
  localparam int MASK_W     = 64;
  localparam int MASK_IDX_W = 6;

  typedef struct packed {
    logic [1:0] operation;
    logic       general_call;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       nack;
    logic       read_valid;
    logic [7:0] read_data;
    logic [1:0] pwm_command;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;        // input beat taken this cycle
    logic capture_out;   // load result register from this beat
    logic capture_read;  // load result register from store read data
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;       // offered beat is a read address match
  } dp_status_t;

endpackage

FILE: hdl/i2crf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/i2crf_ctrl.sv
// Controller for the register-file front end: handshake and read sequencing.
// Depends on i2crf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module i2crf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  i2crf_pkg::dp_status_t status,
  output i2crf_pkg::dp_cmd_t    cmd
);
  import i2crf_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_full, out_full_next;
  logic        accept;

  // Take a beat only when idle and the result register is free or draining
  assign item_ready = (state == ST_IDLE) && (!out_full || result_ready);
  assign accept     = item_valid && item_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.is_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd              = '0;
    cmd.accept       = accept;
    cmd.capture_out  = accept && !status.is_read;
    cmd.capture_read = (state == ST_READ);
  end

  // Result register occupancy: load has priority over drain
  always_comb begin
    out_full_next = out_full;
    if (cmd.capture_out || cmd.capture_read) begin
      out_full_next = 1'b1;
    end else if (result_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign result_valid = out_full;

  `ASSERT_CLK(a_read_one_cycle, state == ST_READ |=> state == ST_IDLE, "read lasted over one cycle")
  `ASSERT_CLK(a_read_slot_free, state == ST_READ |-> !out_full, "result register busy during read")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !out_full), "not idle after reset")

endmodule

FILE: hdl/i2crf_dp.sv
// Datapath for the register-file front end: phase flags, index, write mask,
// byte store with per-entry valid bits, and the result register.
// Depends on i2crf_pkg, i2crf_ram and assert_macros.svh.
`include "assert_macros.svh"
module i2crf_dp #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [63:0]           cfg_write_data,
  input  i2crf_pkg::in_item_t   item,
  input  i2crf_pkg::dp_cmd_t    cmd,
  output i2crf_pkg::dp_status_t status,
  output i2crf_pkg::out_item_t  result
);
  import i2crf_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);

  logic [MASK_W-1:0]      writable_mask;
  logic [IDX_W-1:0]       access_index, access_index_next;
  logic                   expect_index, expect_index_next;
  logic                   expect_payload, expect_payload_next;
  logic                   broadcast_pending, broadcast_pending_next;
  logic                   read_request, read_request_next;
  logic [STORE_DEPTH-1:0] entry_valid;
  logic                   read_hit;
  logic                   wr_en, rd_en;
  logic [7:0]             rd_data;
  logic                   in_range;
  logic                   bad_index;
  out_item_t              beat_out;
  out_item_t              result_q;

  assign status.is_read = (item.operation == OP_READ_ADDR);

  // Index byte checks
  assign in_range  = {1'b0, item.rx_byte} < 9'(STORE_DEPTH);
  assign bad_index = !in_range || !writable_mask[item.rx_byte[MASK_IDX_W-1:0]];

  // Decode one bus event into next state, store access and result
  always_comb begin
    access_index_next      = access_index;
    expect_index_next      = expect_index;
    expect_payload_next    = expect_payload;
    broadcast_pending_next = broadcast_pending;
    read_request_next      = read_request;
    wr_en                  = 1'b0;
    rd_en                  = 1'b0;
    beat_out               = '0;
    case (item.operation)
      OP_WRITE_ADDR: begin
        if (item.general_call) begin
          broadcast_pending_next = 1'b1;
        end else begin
          expect_index_next = 1'b1;
        end
      end
      OP_DATA: begin
        if (expect_index && !broadcast_pending) begin
          expect_index_next   = 1'b0;
          expect_payload_next = 1'b1;
          if (item.rx_byte == READ_REQUEST_CODE) begin
            read_request_next = 1'b1;
          end else begin
            read_request_next = 1'b0;
            if (bad_index) begin
              expect_payload_next    = 1'b0;
              broadcast_pending_next = 1'b0;
              beat_out.nack          = 1'b1;
            end else begin
              access_index_next = item.rx_byte[IDX_W-1:0];
            end
          end
        end else if (expect_payload && !read_request && !broadcast_pending) begin
          wr_en               = 1'b1;
          expect_index_next   = 1'b0;
          expect_payload_next = 1'b0;
          access_index_next   = '0;
        end else if (expect_payload && read_request && !broadcast_pending) begin
          access_index_next   = in_range ? item.rx_byte[IDX_W-1:0] : '0;
          expect_index_next   = 1'b0;
          expect_payload_next = 1'b0;
        end else if (broadcast_pending) begin
          expect_index_next      = 1'b0;
          expect_payload_next    = 1'b0;
          broadcast_pending_next = 1'b0;
          case (item.rx_byte)
            GC_BYTE_APPLY: beat_out.pwm_command = PWM_APPLY;
            GC_BYTE_START: beat_out.pwm_command = PWM_START;
            GC_BYTE_STOP:  beat_out.pwm_command = PWM_STOP;
            default:       beat_out.pwm_command = PWM_NONE;
          endcase
        end
      end
      OP_READ_ADDR: begin
        rd_en             = 1'b1;
        access_index_next = '0;
      end
      default: begin
        // unused code: no change, empty result
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      writable_mask     <= '1;
      access_index      <= '0;
      expect_index      <= 1'b0;
      expect_payload    <= 1'b0;
      broadcast_pending <= 1'b0;
      read_request      <= 1'b0;
      entry_valid       <= '0;
    end else begin
      if (cfg_write_en) begin
        writable_mask <= cfg_write_data;
      end
      if (cmd.accept) begin
        access_index      <= access_index_next;
        expect_index      <= expect_index_next;
        expect_payload    <= expect_payload_next;
        broadcast_pending <= broadcast_pending_next;
        read_request      <= read_request_next;
        if (wr_en) begin
          entry_valid[access_index] <= 1'b1;
        end
      end
    end
  end

  // Sample the entry's valid bit alongside the memory read
  always_ff @(posedge clk) begin
    if (cmd.accept && rd_en) begin
      read_hit <= entry_valid[access_index];
    end
  end

  i2crf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && wr_en),
    .wr_addr (access_index),
    .wr_data (item.rx_byte),
    .rd_en   (cmd.accept && rd_en),
    .rd_addr (access_index),
    .rd_data (rd_data)
  );

  // Result register: event result on a non-read accept, store byte in the cycle after a read is accepted
  always_ff @(posedge clk) begin
    if (cmd.capture_out) begin
      result_q <= beat_out;
    end else if (cmd.capture_read) begin
      result_q.nack        <= 1'b0;
      result_q.read_valid  <= 1'b1;
      result_q.read_data   <= read_hit ? rd_data : 8'h00;
      result_q.pwm_command <= PWM_NONE;
    end
  end

  assign result = result_q;

  `ASSERT_CLK(a_read_result, cmd.capture_read |=> result_q.read_valid, "read result not flagged")
  `ASSERT_CLK(a_no_cmd_clash, !(cmd.capture_out && cmd.capture_read), "two result loads at once")

endmodule

FILE: hdl/i2c_target_register_file_front_end_top.sv
// I2C target register-file front end. Each input beat is one byte event from an
// I2C target bus controller; each yields exactly one result beat (nack, read data
// or a general-call PWM command). Write-address, data and unused events load
// their result on the accepting edge. A read-address event passes through the
// registered read port of the byte store memory and the read state before its
// result is loaded. A new beat is taken while a finished result waits, as long
// as the result register is being drained. The store's reset contents come from
// per-entry valid bits cleared by reset, so no clearing pass follows reset. The
// user must write writable_mask only while idle; the block does not enforce it.
// Depends on i2crf_pkg, i2crf_ctrl, i2crf_dp and i2crf_ram.
module i2c_target_register_file_front_end_top #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [63:0]          cfg_write_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  i2crf_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output i2crf_pkg::out_item_t result
);
  import i2crf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  i2crf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  i2crf_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item),
    .cmd            (cmd),
    .status         (status),
    .result         (result)
  );

endmodule
